// ===== design/tirp_pkg.sv =====
package tirp_pkg;

  // command echo length and derived header layout
  localparam int CommandChars = 7;
  localparam int CmdBits      = 8 * CommandChars;
  localparam int CfgBits      = 56;
  localparam int HeaderLen    = 17;
  localparam int DateChars    = HeaderLen - CommandChars;
  localparam int DateBits     = 40;
  localparam int StatusChars  = 4;
  localparam int HexChars     = 8;

  localparam logic [7:0] AsciiZero = 8'h30;
  localparam logic [7:0] AsciiNine = 8'h39;
  localparam logic [7:0] AsciiAmp  = 8'h26;
  localparam logic [7:0] AsciiUpA  = 8'h41;
  localparam logic [7:0] AsciiUpF  = 8'h46;
  localparam logic [7:0] AsciiLoA  = 8'h61;
  localparam logic [7:0] AsciiLoF  = 8'h66;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_CMD    = 4'd1,
    PH_DATE   = 4'd2,
    PH_REC_A  = 4'd3,
    PH_REC_B  = 4'd4,
    PH_PROD   = 4'd5,
    PH_STATUS = 4'd6,
    PH_COUNT  = 4'd7,
    PH_FIELD  = 4'd8
  } phase_e;

  typedef enum logic [2:0] {
    K_DATE     = 3'd0,
    K_TANK     = 3'd1,
    K_FIELD    = 3'd2,
    K_END      = 3'd3,
    K_MISMATCH = 3'd4,
    K_FORMAT   = 3'd5
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [6:0]  tank_number;
    logic [3:0]  product_digit;
    logic [6:0]  field_count;
    logic [6:0]  field_position;
    logic [31:0] field_bits;
    logic [6:0]  year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic        last_of_tank;
  } result_t;

endpackage

// ===== design/tirp_channels.sv =====
interface tirp_in_if import tirp_pkg::*;;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;

  modport source (output valid, data_byte, frame_start, input ready);
  modport sink   (input valid, data_byte, frame_start, output ready);
endinterface

interface tirp_out_if import tirp_pkg::*;;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [6:0]  tank_number;
  logic [3:0]  product_digit;
  logic [6:0]  field_count;
  logic [6:0]  field_position;
  logic [31:0] field_bits;
  logic [6:0]  year;
  logic [6:0]  month;
  logic [6:0]  day;
  logic [6:0]  hour;
  logic [6:0]  minute;
  logic        last_of_tank;

  modport source (output valid, kind, tank_number, product_digit, field_count,
                  field_position, field_bits, year, month, day, hour, minute,
                  last_of_tank, input ready);
  modport sink   (input valid, kind, tank_number, product_digit, field_count,
                  field_position, field_bits, year, month, day, hour, minute,
                  last_of_tank, output ready);
endinterface

interface tirp_cfg_if import tirp_pkg::*;;
  logic               valid;
  logic               ready;
  logic [CfgBits-1:0] expected_command;

  modport source (output valid, expected_command, input ready);
  modport sink   (input valid, expected_command, output ready);
endinterface

// ===== design/tank_inventory_response_parser.sv =====
// flow: an accepted item waits in the input register, is parsed once the result register
//   can take a value, and its result, if any, is then held in the result register
// throughput: one item per cycle while out_o is not stalled; the input register and the result
//   register let a new item in while a finished result still waits to be taken
// reset: rst_ni asynchronous, active low; parser idles, command register reads zero
module tank_inventory_response_parser
  import tirp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  tirp_in_if.sink    in_i,
  tirp_out_if.source out_o,
  tirp_cfg_if.sink   cfg_i
);

  // ---------------------------------------------------------------------------
  // configuration register, always ready (the user must write it only while idle; the block does not enforce this)
  // ---------------------------------------------------------------------------
  logic [CfgBits-1:0] expected_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_q <= '0;
    end else if (cfg_i.valid) begin
      expected_q <= cfg_i.expected_command;
    end
  end

  // expected command zero-extended to 64 bits; the compare uses only its low CmdBits, the seven command characters
  logic [63:0] expected_ext;
  assign expected_ext = {{(64 - CfgBits){1'b0}}, expected_q};

  // ---------------------------------------------------------------------------
  // handshake: input register feeds the parse step, result register feeds out_o
  // ---------------------------------------------------------------------------
  logic       in_vld_q;
  logic [7:0] byte_q;
  logic       start_q;
  logic       out_vld_q;
  result_t    res_q;
  logic       advance;   // result register can take a new value this cycle
  logic       proc;      // the held item is parsed this cycle

  assign advance    = !out_vld_q || out_o.ready;
  assign proc       = in_vld_q && advance;
  assign in_i.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_vld_q <= 1'b1;
    end else if (proc) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      byte_q  <= in_i.data_byte;
      start_q <= in_i.frame_start;
    end
  end

  // ---------------------------------------------------------------------------
  // parser state
  // ---------------------------------------------------------------------------
  phase_e              phase_q,  phase_d;
  logic [3:0]          cpos_q,   cpos_d;
  logic [CmdBits-1:0]  shift_q,  shift_d;
  logic [DateBits-1:0] date_q,   date_d;
  logic [7:0]          held_q,   held_d;
  logic [6:0]          tank_q,   tank_d;
  logic [3:0]          prod_q,   prod_d;
  logic [6:0]          total_q,  total_d;
  logic [6:0]          left_q,   left_d;
  logic [31:0]         hex_q,    hex_d;
  result_t             res_d;
  logic                res_vld_d;

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= AsciiZero) && (c <= AsciiNine);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_dec(c) || ((c >= AsciiUpA) && (c <= AsciiUpF))
                     || ((c >= AsciiLoA) && (c <= AsciiLoF));
  endfunction

  // letters A-F and a-f carry 1..6 in their low nibble
  function automatic logic [3:0] hex_nib(input logic [7:0] c);
    return is_dec(c) ? c[3:0] : c[3:0] + 4'd9;
  endfunction

  function automatic logic [6:0] two_digit(input logic [3:0] hi, input logic [3:0] lo);
    return 7'({3'b0, hi} * 7'd10) + {3'b0, lo};
  endfunction

  always_comb begin
    phase_e              ph;
    logic [3:0]          cpos;
    logic [3:0]          cpos_inc;
    logic [CmdBits-1:0]  shift;
    logic [DateBits-1:0] date;
    logic [7:0]          held;
    logic [6:0]          tank;
    logic [3:0]          prod;
    logic [6:0]          total;
    logic [6:0]          left;
    logic [31:0]         hex;
    logic [6:0]          left_dec;

    // frame start restarts the parse whatever the phase
    ph    = start_q ? PH_CMD : phase_q;
    cpos  = start_q ? '0 : cpos_q;
    shift = start_q ? '0 : shift_q;
    date  = start_q ? '0 : date_q;
    held  = start_q ? '0 : held_q;
    tank  = start_q ? '0 : tank_q;
    prod  = start_q ? '0 : prod_q;
    total = start_q ? '0 : total_q;
    left  = start_q ? '0 : left_q;
    hex   = start_q ? '0 : hex_q;
    cpos_inc = cpos + 4'd1;
    left_dec = '0;

    phase_d   = phase_q;
    cpos_d    = cpos_q;
    shift_d   = shift_q;
    date_d    = date_q;
    held_d    = held_q;
    tank_d    = tank_q;
    prod_d    = prod_q;
    total_d   = total_q;
    left_d    = left_q;
    hex_d     = hex_q;
    res_d     = '0;
    res_vld_d = 1'b0;

    if (proc) begin
      phase_d = ph;
      cpos_d  = cpos;
      shift_d = shift;
      date_d  = date;
      held_d  = held;
      tank_d  = tank;
      prod_d  = prod;
      total_d = total;
      left_d  = left;
      hex_d   = hex;

      case (ph)
        PH_CMD: begin
          shift_d = CmdBits'({shift, byte_q});
          cpos_d  = cpos_inc;
          if (cpos_inc >= 4'(CommandChars)) begin
            cpos_d = '0;
            if (shift_d != expected_ext[CmdBits-1:0]) begin
              phase_d    = PH_IDLE;
              res_vld_d  = 1'b1;
              res_d.kind = K_MISMATCH;
            end else begin
              phase_d = PH_DATE;
            end
          end
        end
        PH_DATE: begin
          if (!is_dec(byte_q)) begin
            phase_d    = PH_IDLE;
            res_vld_d  = 1'b1;
            res_d.kind = K_FORMAT;
          end else begin
            date_d = {date[DateBits-5:0], byte_q[3:0]};
            cpos_d = cpos_inc;
            if (cpos_inc >= 4'(DateChars)) begin
              cpos_d       = '0;
              phase_d      = PH_REC_A;
              res_vld_d    = 1'b1;
              res_d.kind   = K_DATE;
              res_d.year   = two_digit(date_d[39:36], date_d[35:32]);
              res_d.month  = two_digit(date_d[31:28], date_d[27:24]);
              res_d.day    = two_digit(date_d[23:20], date_d[19:16]);
              res_d.hour   = two_digit(date_d[15:12], date_d[11:8]);
              res_d.minute = two_digit(date_d[7:4], date_d[3:0]);
            end
          end
        end
        PH_REC_A: begin
          held_d  = byte_q;
          phase_d = PH_REC_B;
        end
        PH_REC_B: begin
          if (byte_q == AsciiAmp) begin
            // end of message mark
            phase_d    = PH_IDLE;
            res_vld_d  = 1'b1;
            res_d.kind = K_END;
          end else if (!is_dec(held) || !is_dec(byte_q)) begin
            phase_d    = PH_IDLE;
            res_vld_d  = 1'b1;
            res_d.kind = K_FORMAT;
          end else begin
            tank_d  = two_digit(held[3:0], byte_q[3:0]);
            phase_d = PH_PROD;
          end
        end
        PH_PROD: begin
          if (!is_dec(byte_q)) begin
            phase_d    = PH_IDLE;
            res_vld_d  = 1'b1;
            res_d.kind = K_FORMAT;
          end else begin
            prod_d  = byte_q[3:0];
            cpos_d  = '0;
            phase_d = PH_STATUS;
          end
        end
        PH_STATUS: begin
          // status characters are skipped
          cpos_d = cpos_inc;
          if (cpos_inc >= 4'(StatusChars)) begin
            cpos_d  = '0;
            phase_d = PH_COUNT;
          end
        end
        PH_COUNT: begin
          if (!is_dec(byte_q)) begin
            phase_d    = PH_IDLE;
            res_vld_d  = 1'b1;
            res_d.kind = K_FORMAT;
          end else if (cpos == '0) begin
            held_d = {4'b0, byte_q[3:0]};
            cpos_d = 4'd1;
          end else begin
            cpos_d              = '0;
            total_d             = two_digit(held[3:0], byte_q[3:0]);
            left_d              = total_d;
            hex_d               = '0;
            res_vld_d           = 1'b1;
            res_d.kind          = K_TANK;
            res_d.tank_number   = tank;
            res_d.product_digit = prod;
            res_d.field_count   = total_d;
            if (total_d == '0) begin
              // header of an empty record completes it
              res_d.last_of_tank = 1'b1;
              phase_d            = PH_REC_A;
            end else begin
              phase_d = PH_FIELD;
            end
          end
        end
        PH_FIELD: begin
          if (!is_hex(byte_q)) begin
            phase_d    = PH_IDLE;
            res_vld_d  = 1'b1;
            res_d.kind = K_FORMAT;
          end else begin
            hex_d  = {hex[27:0], hex_nib(byte_q)};
            cpos_d = cpos_inc;
            if (cpos_inc >= 4'(HexChars)) begin
              cpos_d               = '0;
              res_vld_d            = 1'b1;
              res_d.kind           = K_FIELD;
              res_d.tank_number    = tank;
              res_d.product_digit  = prod;
              res_d.field_count    = total;
              res_d.field_position = total - left;
              res_d.field_bits     = hex_d;
              hex_d                = '0;
              left_dec             = (left != '0) ? left - 7'd1 : left;
              left_d               = left_dec;
              if (left_dec == '0) begin
                res_d.last_of_tank = 1'b1;
                phase_d            = PH_REC_A;
              end
            end
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cpos_q  <= '0;
      shift_q <= '0;
      date_q  <= '0;
      held_q  <= '0;
      tank_q  <= '0;
      prod_q  <= '0;
      total_q <= '0;
      left_q  <= '0;
      hex_q   <= '0;
    end else begin
      phase_q <= phase_d;
      cpos_q  <= cpos_d;
      shift_q <= shift_d;
      date_q  <= date_d;
      held_q  <= held_d;
      tank_q  <= tank_d;
      prod_q  <= prod_d;
      total_q <= total_d;
      left_q  <= left_d;
      hex_q   <= hex_d;
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= proc && res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && res_vld_d) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.kind           = res_q.kind;
  assign out_o.tank_number    = res_q.tank_number;
  assign out_o.product_digit  = res_q.product_digit;
  assign out_o.field_count    = res_q.field_count;
  assign out_o.field_position = res_q.field_position;
  assign out_o.field_bits     = res_q.field_bits;
  assign out_o.year           = res_q.year;
  assign out_o.month          = res_q.month;
  assign out_o.day            = res_q.day;
  assign out_o.hour           = res_q.hour;
  assign out_o.minute         = res_q.minute;
  assign out_o.last_of_tank   = res_q.last_of_tank;

endmodule

// ===== design/tirp_checker.sv =====
module tirp_checker
  import tirp_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [2:0]  out_kind_i,
  input logic [31:0] out_field_bits_i,
  input logic        out_last_i
);

  // a waiting result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // a waiting result keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_field_bits_i) && $stable(out_kind_i))
    else $error("result changed while stalled");

  // with the result side empty the input is never held off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty result register");

  // field value only on field results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i != K_FIELD |-> out_field_bits_i == '0)
    else $error("field bits on a non-field result");

  // record completion only on header or field results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_last_i |-> out_kind_i == K_TANK || out_kind_i == K_FIELD)
    else $error("last_of_tank on a wrong result kind");

endmodule

bind tank_inventory_response_parser tirp_checker u_tirp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_kind_i       (out_o.kind),
  .out_field_bits_i (out_o.field_bits),
  .out_last_i       (out_o.last_of_tank)
);

// ===== tb/tank_inventory_response_parser_test.sv =====
module tank_inventory_response_parser_test;
  import tirp_pkg::*;

  // run limits and the quiet time after the last expected result
  localparam int unsigned CycleLimit   = 400000;
  localparam int          SettleCycles = 16;

  // command values used across the run
  localparam logic [CfgBits-1:0] EchoCommand    = {8'h01, "I20100"};
  localparam logic [CfgBits-1:0] AllOnesCommand = {CfgBits{1'b1}};

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #4 clk_i = ~clk_i;

  // channels toward the block
  tirp_in_if  in_if ();
  tirp_out_if out_if ();
  tirp_cfg_if cfg_if ();

  tank_inventory_response_parser dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // shared run state
  int unsigned cycle_count   = 0;
  int unsigned fault_count   = 0;
  int unsigned parsed_items  = 0;
  bit          idling        = 1'b1;
  int          send_gap_odds = 6;
  result_t     awaited_records[$];
  result_t     head_record;
  logic [7:0]  frame_q[$];

  // parser mirror: register copy and parse state
  logic [CfgBits-1:0] command_reg = '0;
  phase_e             parse_phase = PH_IDLE;
  logic [3:0]         char_count = '0;
  logic [CmdBits-1:0] echo_shift = '0;
  logic [DateBits-1:0] date_nibbles = '0;
  logic [7:0]         first_char = '0;
  logic [6:0]         tank_no = '0;
  logic [3:0]         product_no = '0;
  logic [6:0]         fields_in_tank = '0;
  logic [6:0]         fields_remaining = '0;
  logic [31:0]        hex_word = '0;

  // ---------------------------------------------------------------------------
  // character classes
  // ---------------------------------------------------------------------------

  function automatic int dec_digit(logic [7:0] c);
    if (c >= AsciiZero && c <= AsciiNine) return int'(c) - int'(AsciiZero);
    return -1;
  endfunction

  function automatic int hex_digit(logic [7:0] c);
    if (c >= AsciiZero && c <= AsciiNine) return int'(c) - int'(AsciiZero);
    if (c >= AsciiUpA && c <= AsciiUpF) return int'(c) - int'(AsciiUpA) + 10;
    if (c >= AsciiLoA && c <= AsciiLoF) return int'(c) - int'(AsciiLoA) + 10;
    return -1;
  endfunction

  function automatic logic [6:0] date_pair(int k);
    return 7'(date_nibbles[4*(9-k) +: 4] * 10 + date_nibbles[4*(8-k) +: 4]);
  endfunction

  // header fields of the current tank record
  function automatic result_t record_of(kind_e k);
    result_t r;
    r = '0;
    r.kind          = k;
    r.tank_number   = tank_no;
    r.product_digit = product_no;
    r.field_count   = fields_in_tank;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // parser mirror: one accepted character, returns 1 when a result is due
  // ---------------------------------------------------------------------------

  function automatic bit parse_char(input logic [7:0] b, input logic fs,
                                    output result_t rec);
    int d;
    bit bad;
    bit emitted;
    rec     = '0;
    bad     = 1'b0;
    emitted = 1'b0;

    // frame start wipes everything and the byte is the first command char
    if (fs) begin
      parse_phase      = PH_CMD;
      char_count       = '0;
      echo_shift       = '0;
      date_nibbles     = '0;
      first_char       = '0;
      tank_no          = '0;
      product_no       = '0;
      fields_in_tank   = '0;
      fields_remaining = '0;
      hex_word         = '0;
    end

    case (parse_phase)
      PH_IDLE: begin
        // stray byte outside a frame
      end
      PH_CMD: begin
        echo_shift = {echo_shift[CmdBits-9:0], b};
        char_count = char_count + 1'b1;
        if (char_count >= CommandChars) begin
          char_count = '0;
          if (echo_shift != CmdBits'(command_reg)) begin
            // mismatch shows up with the last command char, then idle
            parse_phase = PH_IDLE;
            rec.kind    = K_MISMATCH;
            emitted     = 1'b1;
          end else begin
            parse_phase = PH_DATE;
          end
        end
      end
      PH_DATE: begin
        d = dec_digit(b);
        if (d < 0) begin
          bad = 1'b1;
        end else begin
          date_nibbles = {date_nibbles[DateBits-5:0], 4'(d)};
          char_count   = char_count + 1'b1;
          if (char_count >= DateChars) begin
            char_count  = '0;
            parse_phase = PH_REC_A;
            rec.kind    = K_DATE;
            rec.year    = date_pair(0);
            rec.month   = date_pair(2);
            rec.day     = date_pair(4);
            rec.hour    = date_pair(6);
            rec.minute  = date_pair(8);
            emitted     = 1'b1;
          end
        end
      end
      PH_REC_A: begin
        first_char  = b;
        parse_phase = PH_REC_B;
      end
      PH_REC_B: begin
        // only the second char of a record can carry the end mark
        if (b == AsciiAmp) begin
          parse_phase = PH_IDLE;
          rec.kind    = K_END;
          emitted     = 1'b1;
        end else if (dec_digit(first_char) < 0 || dec_digit(b) < 0) begin
          bad = 1'b1;
        end else begin
          tank_no     = 7'(dec_digit(first_char) * 10 + dec_digit(b));
          parse_phase = PH_PROD;
        end
      end
      PH_PROD: begin
        d = dec_digit(b);
        if (d < 0) begin
          bad = 1'b1;
        end else begin
          product_no  = 4'(d);
          char_count  = '0;
          parse_phase = PH_STATUS;
        end
      end
      PH_STATUS: begin
        // status chars are skipped whatever they hold
        char_count = char_count + 1'b1;
        if (char_count >= StatusChars) begin
          char_count  = '0;
          parse_phase = PH_COUNT;
        end
      end
      PH_COUNT: begin
        d = dec_digit(b);
        if (d < 0) begin
          bad = 1'b1;
        end else if (char_count == 0) begin
          first_char = 8'(d);
          char_count = 4'd1;
        end else begin
          char_count       = '0;
          fields_in_tank   = 7'(first_char * 10 + d);
          fields_remaining = fields_in_tank;
          hex_word         = '0;
          rec              = record_of(K_TANK);
          emitted          = 1'b1;
          // a record without fields is complete with its header
          if (fields_in_tank == 0) begin
            rec.last_of_tank = 1'b1;
            parse_phase      = PH_REC_A;
          end else begin
            parse_phase = PH_FIELD;
          end
        end
      end
      PH_FIELD: begin
        d = hex_digit(b);
        if (d < 0) begin
          bad = 1'b1;
        end else begin
          hex_word   = {hex_word[27:0], 4'(d)};
          char_count = char_count + 1'b1;
          if (char_count >= HexChars) begin
            char_count         = '0;
            rec                = record_of(K_FIELD);
            rec.field_position = 7'(fields_in_tank - fields_remaining);
            rec.field_bits     = hex_word;
            hex_word           = '0;
            emitted            = 1'b1;
            if (fields_remaining > 0) fields_remaining = fields_remaining - 1'b1;
            if (fields_remaining == 0) begin
              rec.last_of_tank = 1'b1;
              parse_phase      = PH_REC_A;
            end
          end
        end
      end
      default: begin
        parse_phase = PH_IDLE;
      end
    endcase

    // any bad digit drops the frame with a format error
    if (bad) begin
      rec         = '0;
      rec.kind    = K_FORMAT;
      parse_phase = PH_IDLE;
    end
    return bad || emitted;
  endfunction

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  task automatic note_fault(string what);
    fault_count++;
    if (fault_count <= 10) $display("cycle %0d: %s", cycle_count, what);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      note_fault($sformatf("%s expected %0h actual %0h (expected kind %0d)",
                           name, want, got, head_record.kind));
    end
  endtask

  // every taken result is matched against the oldest expected one
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (awaited_records.size() == 0) begin
        note_fault($sformatf("result of kind %0d with nothing expected", out_if.kind));
      end else begin
        head_record = awaited_records.pop_front();
        check_field("kind", head_record.kind, out_if.kind);
        check_field("tank_number", head_record.tank_number, out_if.tank_number);
        check_field("product_digit", head_record.product_digit, out_if.product_digit);
        check_field("field_count", head_record.field_count, out_if.field_count);
        check_field("field_position", head_record.field_position, out_if.field_position);
        check_field("field_bits", head_record.field_bits, out_if.field_bits);
        check_field("year", head_record.year, out_if.year);
        check_field("month", head_record.month, out_if.month);
        check_field("day", head_record.day, out_if.day);
        check_field("hour", head_record.hour, out_if.hour);
        check_field("minute", head_record.minute, out_if.minute);
        check_field("last_of_tank", head_record.last_of_tank, out_if.last_of_tank);
      end
    end
  end

  // hard stop if the block hangs
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side: ready with random stall bursts while idling is set
  initial begin
    out_if.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (idling && $urandom_range(0, 7) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  // ---------------------------------------------------------------------------
  // driving
  // ---------------------------------------------------------------------------

  // one character item; valid stays high into the next call unless a gap comes
  task automatic send_byte(input logic [7:0] b, input logic fs);
    result_t rec;
    bit      ignored;
    if (send_gap_odds != 0 && $urandom_range(1, send_gap_odds) == 1) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.data_byte   <= b;
    in_if.frame_start <= fs;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    ignored = (parse_phase == PH_IDLE) && !fs;
    if (parse_char(b, fs, rec)) awaited_records.push_back(rec);
    if (!ignored) parsed_items++;
  endtask

  // drop valid and wait until the block has nothing left in flight
  task automatic settle();
    in_if.valid <= 1'b0;
    while (awaited_records.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic load_command(input logic [CfgBits-1:0] c);
    cfg_if.valid            <= 1'b1;
    cfg_if.expected_command <= c;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    cfg_if.valid <= 1'b0;
    command_reg = c;
  endtask

  // ---------------------------------------------------------------------------
  // frame building
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] hex_char(logic [3:0] v, bit lower);
    if (v < 10) return 8'(AsciiZero + v);
    return 8'((lower ? AsciiLoA : AsciiUpA) + v - 10);
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) frame_q.push_back(s[i]);
  endfunction

  function automatic void put_command(logic [CfgBits-1:0] c);
    for (int i = CommandChars - 1; i >= 0; i--) frame_q.push_back(c[8*i +: 8]);
  endfunction

  function automatic void put_digits2(int v);
    frame_q.push_back(8'(AsciiZero + v / 10));
    frame_q.push_back(8'(AsciiZero + v % 10));
  endfunction

  function automatic void put_status();
    repeat (StatusChars) frame_q.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void put_field(logic [31:0] v);
    for (int i = 7; i >= 0; i--) begin
      frame_q.push_back(hex_char(v[4*i +: 4], 1'($urandom_range(0, 1))));
    end
  endfunction

  function automatic void put_record(int tank, int prod, int count);
    put_digits2(tank);
    frame_q.push_back(8'(AsciiZero + prod));
    put_status();
    put_digits2(count);
    repeat (count) put_field($urandom);
  endfunction

  // matching command and a fixed date, parser left at a record start
  function automatic void put_header();
    put_command(command_reg);
    put_text("2401311530");
  endfunction

  task automatic send_frame();
    foreach (frame_q[i]) send_byte(frame_q[i], i == 0);
    frame_q.delete();
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // command register reads zero after reset; extreme dates and fields
  task automatic test_zero_command();
    put_command('0);
    put_text("9999999999");
    put_record(0, 0, 0);
    put_text("999");
    put_status();
    put_text("02ffffffff00000000");
    put_text("9&");
    send_frame();
    put_command('0);
    put_text("0000000000");
    put_text("000");
    put_status();
    put_text("01A0b1C2d3");
    put_text("&&");
    send_frame();
  endtask

  // wrong echo reported once, trailing bytes ignored while idle
  task automatic test_command_mismatch();
    put_command(EchoCommand);
    put_text("2401311530");
    send_frame();
    repeat (3) send_byte(8'($urandom_range(0, 255)), 1'b0);
    // only the last char differs
    put_command(56'h1);
    send_frame();
    settle();
    load_command(EchoCommand);
    // only the first char differs
    put_command({8'h02, EchoCommand[47:0]});
    put_text("2401311530");
    send_frame();
  endtask

  // non-digit and non-hex chars at each place the parser checks
  task automatic test_bad_characters();
    string bad_hex;
    bad_hex = "G@`g/:";
    put_command(command_reg);
    put_text("24/");
    send_frame();
    put_command(command_reg);
    put_text("240131153:");
    send_frame();
    put_header(); put_text("A1");        send_frame();
    put_header(); put_text("1:");        send_frame();
    // end mark in the first place of a record is just a bad digit
    put_header(); put_text("&1");        send_frame();
    put_header(); put_text("01/");       send_frame();
    put_header(); put_text("015ABCD:");  send_frame();
    put_header(); put_text("015ABCD1/"); send_frame();
    for (int i = 0; i < bad_hex.len(); i++) begin
      put_header();
      put_text("015ABCD01aB3dE5f");
      frame_q.push_back(bad_hex[i]);
      send_frame();
    end
  endtask

  // a new frame start cuts off whatever is in progress
  task automatic test_frame_restart();
    put_text("\001I2");
    send_frame();
    put_header();
    put_text("0");
    send_frame();
    put_header();
    put_text("123ABCD01abc");
    send_frame();
    put_header();
    put_record(7, 3, 1);
    put_text("0&");
    send_frame();
  endtask

  // all-ones command, widest field count
  task automatic test_longest_record();
    settle();
    load_command(AllOnesCommand);
    put_header();
    put_record(99, 9, 99);
    put_record(42, 5, 0);
    put_text("&&");
    send_frame();
  endtask

  // mostly well-formed frames with random content, some broken or noise
  task automatic random_frame();
    int                 shape;
    int                 cut;
    logic [CfgBits-1:0] cmd;
    shape         = $urandom_range(0, 99);
    cmd           = command_reg;
    send_gap_odds = (!idling || $urandom_range(0, 2) == 0) ? 0 : 6;
    if (shape < 6) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      if (shape < 14) cmd[8*$urandom_range(0, CommandChars - 1) +: 8] ^= 8'($urandom_range(1, 255));
      put_command(cmd);
      for (int i = 0; i < DateChars; i++) frame_q.push_back(8'(AsciiZero + $urandom_range(0, 9)));
      repeat ($urandom_range(0, 4)) begin
        put_record($urandom_range(0, 99), $urandom_range(0, 9),
                   ($urandom_range(0, 9) == 0) ? $urandom_range(4, 16) : $urandom_range(0, 3));
      end
      frame_q.push_back(8'($urandom_range(0, 255)));
      frame_q.push_back(AsciiAmp);
      // one char overwritten anywhere after the start
      if (shape >= 80 && shape < 92) begin
        frame_q[$urandom_range(1, frame_q.size() - 1)] = 8'($urandom_range(0, 255));
      end
      // frame cut short, the next start takes over mid-parse
      if (shape >= 92) begin
        cut = $urandom_range(1, frame_q.size() - 1);
        while (frame_q.size() > cut) void'(frame_q.pop_back());
      end
      send_frame();
    end
  endtask

  task automatic test_random_traffic(input logic [CfgBits-1:0] cmd, input int target,
                                     input bit with_idling);
    int unsigned first;
    settle();
    idling = with_idling;
    load_command(cmd);
    first = parsed_items;
    while (parsed_items - first < target) random_frame();
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    in_if.valid             <= 1'b0;
    in_if.data_byte         <= '0;
    in_if.frame_start       <= 1'b0;
    cfg_if.valid            <= 1'b0;
    cfg_if.expected_command <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_zero_command();
    test_command_mismatch();
    test_bad_characters();
    test_frame_restart();
    test_longest_record();
    test_random_traffic(CfgBits'({$urandom, $urandom}), 60, 1'b1);
    test_random_traffic(EchoCommand, 40, 1'b1);
    // closing stretch runs flat out on both sides
    test_random_traffic(CfgBits'({$urandom, $urandom}), 40, 1'b0);
    settle();

    if (fault_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
